@@ rtl/psar_pkg.sv @@
// -----------------------------------------------------------------------------
// psar_pkg: shared types, codes and helpers of the scroll address unit
// Holds the request codes, payload structs, address masks and the
// coarse X increment and fine/coarse Y increment functions.
// -----------------------------------------------------------------------------
`default_nettype none

package psar_pkg;

   localparam int ADDR_W  = 15;
   localparam int FETCH_W = 14;

   typedef enum logic [3:0] {
      ACT_CTRL_WR   = 4'd0,
      ACT_MASK_WR   = 4'd1,
      ACT_SCROLL_WR = 4'd2,
      ACT_ADDR_WR   = 4'd3,
      ACT_DATA_ACC  = 4'd4,
      ACT_STATUS_RD = 4'd5,
      ACT_VBL_START = 4'd6,
      ACT_VBL_END   = 4'd7,
      ACT_INC_X     = 4'd8,
      ACT_INC_Y     = 4'd9,
      ACT_COPY_X    = 4'd10,
      ACT_COPY_Y    = 4'd11
   } action_type;

   localparam logic [ADDR_W-1:0]  X_BITS         = 15'h041F;
   localparam logic [ADDR_W-1:0]  Y_BITS         = 15'h7BE0;
   localparam logic [ADDR_W-1:0]  CTRL_KEEP      = 15'h73FF;
   localparam logic [ADDR_W-1:0]  SCROLL1_KEEP   = 15'h7FE0;
   localparam logic [ADDR_W-1:0]  SCROLL2_KEEP   = 15'h0C1F;
   localparam logic [ADDR_W-1:0]  ADDR1_KEEP     = 15'h00FF;
   localparam logic [ADDR_W-1:0]  ADDR2_KEEP     = 15'h7F00;
   localparam logic [FETCH_W-1:0] NAME_BASE      = 14'h2000;
   localparam logic [FETCH_W-1:0] ATTR_BASE      = 14'h23C0;
   localparam logic [4:0]         COARSE_Y_LAST  = 5'd29;
   localparam logic [4:0]         COARSE_Y_MAX   = 5'd31;

   typedef struct packed {
      logic [3:0] action;
      logic [7:0] value;
   } req_item_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  cur_address;
      logic [2:0]         fine_x;
      logic               toggle;
      logic               nmi_pulse;
      logic               vblank_status;
      logic [FETCH_W-1:0] name_fetch_address;
      logic [FETCH_W-1:0] attr_fetch_address;
   } rsp_item_type;

   function automatic logic [ADDR_W-1:0] bump_x(input logic [ADDR_W-1:0] v);
      logic [ADDR_W-1:0] r;
      r = v;
      if (v[4:0] == 5'h1F) begin
         r = v ^ X_BITS;
      end else begin
         r[4:0] = v[4:0] + 5'd1;
      end
      return r;
   endfunction

   function automatic logic [ADDR_W-1:0] bump_y(input logic [ADDR_W-1:0] v);
      logic [ADDR_W-1:0] r;
      logic [4:0]        cy;
      r  = v;
      cy = v[9:5];
      if (v[14:12] != 3'b111) begin
         r[14:12] = v[14:12] + 3'd1;
      end else begin
         r[14:12] = 3'b000;
         if (cy == COARSE_Y_LAST) begin
            r[9:5] = 5'd0;
            r[11]  = ~v[11];
         end else if (cy == COARSE_Y_MAX) begin
            r[9:5] = 5'd0;
         end else begin
            r[9:5] = cy + 5'd1;
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ rtl/psar_if.sv @@
// -----------------------------------------------------------------------------
// psar_req_if / psar_rsp_if: request and result channels
// Valid/ready channels carrying the request fields and the result fields.
// -----------------------------------------------------------------------------
`default_nettype none

interface psar_req_if
   import psar_pkg::*;
   ;
   logic       valid;
   logic       ready;
   logic [3:0] action;
   logic [7:0] value;

   modport source (output valid, output action, output value, input ready);
   modport sink   (input valid, input action, input value, output ready);
endinterface

interface psar_rsp_if
   import psar_pkg::*;
   ;
   logic               valid;
   logic               ready;
   logic [ADDR_W-1:0]  cur_address;
   logic [2:0]         fine_x;
   logic               toggle;
   logic               nmi_pulse;
   logic               vblank_status;
   logic [FETCH_W-1:0] name_fetch_address;
   logic [FETCH_W-1:0] attr_fetch_address;

   modport source (output valid, output cur_address, output fine_x, output toggle,
                   output nmi_pulse, output vblank_status, output name_fetch_address,
                   output attr_fetch_address, input ready);
   modport sink   (input valid, input cur_address, input fine_x, input toggle,
                   input nmi_pulse, input vblank_status, input name_fetch_address,
                   input attr_fetch_address, output ready);
endinterface

`default_nettype wire

@@ rtl/ppu_scroll_address_registers_unit.sv @@
// -----------------------------------------------------------------------------
// ppu_scroll_address_registers_unit: scroll and VRAM address registers
// Applies CPU register accesses and render-timing events to the address
// state and returns the resulting addresses and flags for every request.
//
//   channel   dir  handshake           payload
//   req_chan  in   valid / ready       action, value
//   rsp_chan  out  valid / ready       addresses, fine_x, toggle, nmi, vblank
//
// A request is captured in the input register and is applied to the
// state as it moves into the result register, which then holds its result.
// One request is accepted in every cycle unless the result register stalls.
// Synchronous reset clears the state, except vblank, which comes up set.
// A stalled result register holds the input register, which then stalls
// the request side.
// -----------------------------------------------------------------------------
`default_nettype none

module ppu_scroll_address_registers_unit
   import psar_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   psar_req_if.sink   req_chan,
   psar_rsp_if.source rsp_chan
);

   logic         item_valid;
   logic         can_load;
   logic         fire;
   req_item_type item;
   rsp_item_type result;

   assign fire = item_valid && can_load;

   psar_req_stage u_req_stage (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .advance    (fire),
      .item_valid (item_valid),
      .item       (item)
   );

   psar_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (item),
      .result (result)
   );

   psar_rsp_stage u_rsp_stage (
      .clock    (clock),
      .reset    (reset),
      .load     (fire),
      .result   (result),
      .can_load (can_load),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

@@ rtl/psar_req_stage.sv @@
// -----------------------------------------------------------------------------
// psar_req_stage: request input register
// Captures one request and holds it until the core consumes it.
// -----------------------------------------------------------------------------
`default_nettype none

module psar_req_stage
   import psar_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   psar_req_if.sink    req_chan,
   input  wire logic   advance,
   output logic        item_valid,
   output req_item_type item
);

   logic         valid_ff;
   logic         valid_in;
   logic         accept;
   req_item_type item_ff;

   assign req_chan.ready = !valid_ff || advance;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (accept) begin
         item_ff.action <= req_chan.action;
         item_ff.value  <= req_chan.value;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

@@ rtl/psar_core.sv @@
// -----------------------------------------------------------------------------
// psar_core: scroll and address state
// Holds the current and temporary addresses, fine X, write toggle, control
// bits and vblank flags, and forms the result of each consumed request.
// -----------------------------------------------------------------------------
`default_nettype none

module psar_core
   import psar_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         fire,
   input  wire req_item_type item,
   output rsp_item_type      result
);

   logic [ADDR_W-1:0] current_addr_ff, current_addr_in;
   logic [ADDR_W-1:0] temp_addr_ff, temp_addr_in;
   logic [2:0]        fine_x_ff, fine_x_in;
   logic              second_write_ff, second_write_in;
   logic              nmi_enable_ff, nmi_enable_in;
   logic              step_by_row_ff, step_by_row_in;
   logic              render_en_ff, render_en_in;
   logic              vblank_ff, vblank_in;
   logic              in_blank_ff, in_blank_in;
   logic              nmi;
   logic              vbl_out;
   logic [7:0]        val;

   assign val = item.value;

   always_comb begin
      current_addr_in = current_addr_ff;
      temp_addr_in    = temp_addr_ff;
      fine_x_in       = fine_x_ff;
      second_write_in = second_write_ff;
      nmi_enable_in   = nmi_enable_ff;
      step_by_row_in  = step_by_row_ff;
      render_en_in    = render_en_ff;
      vblank_in       = vblank_ff;
      in_blank_in     = in_blank_ff;
      nmi             = 1'b0;
      case (item.action)
         ACT_CTRL_WR: begin
            nmi_enable_in  = val[7];
            step_by_row_in = val[2];
            nmi            = val[7] && !nmi_enable_ff && vblank_ff;
            temp_addr_in   = (temp_addr_ff & CTRL_KEEP) | {3'b000, val[1:0], 10'd0};
         end
         ACT_MASK_WR: begin
            render_en_in = val[3] || val[4];
         end
         ACT_SCROLL_WR: begin
            if (!second_write_ff) begin
               fine_x_in    = val[2:0];
               temp_addr_in = (temp_addr_ff & SCROLL1_KEEP) | {10'd0, val[7:3]};
            end else begin
               temp_addr_in = (temp_addr_ff & SCROLL2_KEEP)
                            | {val[2:0], 2'b00, val[7:3], 5'd0};
            end
            second_write_in = !second_write_ff;
         end
         ACT_ADDR_WR: begin
            if (!second_write_ff) begin
               temp_addr_in = (temp_addr_ff & ADDR1_KEEP) | {1'b0, val[5:0], 8'd0};
            end else begin
               temp_addr_in    = (temp_addr_ff & ADDR2_KEEP) | {7'd0, val};
               current_addr_in = temp_addr_in;
            end
            second_write_in = !second_write_ff;
         end
         ACT_DATA_ACC: begin
            if (render_en_ff && !in_blank_ff) begin
               current_addr_in = bump_y(bump_x(current_addr_ff));
            end else if (step_by_row_ff) begin
               current_addr_in = current_addr_ff + 15'd32;
            end else begin
               current_addr_in = current_addr_ff + 15'd1;
            end
         end
         ACT_STATUS_RD: begin
            current_addr_in = current_addr_ff;
         end
         ACT_VBL_START: begin
            vblank_in   = 1'b1;
            in_blank_in = 1'b1;
            nmi         = nmi_enable_ff;
         end
         ACT_VBL_END: begin
            vblank_in   = 1'b0;
            in_blank_in = 1'b0;
         end
         ACT_INC_X: begin
            if (render_en_ff) begin
               current_addr_in = bump_x(current_addr_ff);
            end
         end
         ACT_INC_Y: begin
            if (render_en_ff) begin
               current_addr_in = bump_y(current_addr_ff);
            end
         end
         ACT_COPY_X: begin
            if (render_en_ff) begin
               current_addr_in = (current_addr_ff & ~X_BITS) | (temp_addr_ff & X_BITS);
            end
         end
         ACT_COPY_Y: begin
            if (render_en_ff) begin
               current_addr_in = (current_addr_ff & ~Y_BITS) | (temp_addr_ff & Y_BITS);
            end
         end
         default: begin
            nmi = 1'b0;
         end
      endcase

      vbl_out = vblank_in;
      if (item.action == ACT_STATUS_RD) begin
         vblank_in       = 1'b0;
         second_write_in = 1'b0;
      end
   end

   always_comb begin
      result.cur_address        = current_addr_in;
      result.fine_x             = fine_x_in;
      result.toggle             = second_write_in;
      result.nmi_pulse          = nmi;
      result.vblank_status      = vbl_out;
      result.name_fetch_address = NAME_BASE | {2'b00, current_addr_in[11:0]};
      result.attr_fetch_address = ATTR_BASE | {2'b00, current_addr_in[11:10], 4'd0,
                                                current_addr_in[9:7], current_addr_in[4:2]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         current_addr_ff <= '0;
         temp_addr_ff    <= '0;
         fine_x_ff       <= '0;
         second_write_ff <= 1'b0;
         nmi_enable_ff   <= 1'b0;
         step_by_row_ff  <= 1'b0;
         render_en_ff    <= 1'b0;
         vblank_ff       <= 1'b1;
         in_blank_ff     <= 1'b0;
      end else if (fire) begin
         current_addr_ff <= current_addr_in;
         temp_addr_ff    <= temp_addr_in;
         fine_x_ff       <= fine_x_in;
         second_write_ff <= second_write_in;
         nmi_enable_ff   <= nmi_enable_in;
         step_by_row_ff  <= step_by_row_in;
         render_en_ff    <= render_en_in;
         vblank_ff       <= vblank_in;
         in_blank_ff     <= in_blank_in;
      end
   end

   // A status read always leaves the flag and the write toggle clear.
   a_status_clears: assert property (@(posedge clock) disable iff (reset)
      fire && item.action == ACT_STATUS_RD |=> !vblank_ff && !second_write_ff)
      else $error("status read did not clear vblank or toggle");

   a_nmi_source: assert property (@(posedge clock) disable iff (reset)
      fire && result.nmi_pulse |-> item.action == ACT_CTRL_WR
                                   || item.action == ACT_VBL_START)
      else $error("NMI raised by an unexpected request");

   a_vbl_end: assert property (@(posedge clock) disable iff (reset)
      fire && item.action == ACT_VBL_END |=> !vblank_ff && !in_blank_ff)
      else $error("vblank end left a flag set");

   a_hold_idle: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(current_addr_ff) && $stable(temp_addr_ff))
      else $error("address state changed without a request");

endmodule

`default_nettype wire

@@ rtl/psar_rsp_stage.sv @@
// -----------------------------------------------------------------------------
// psar_rsp_stage: result output register
// Holds one result until the downstream side takes it.
// -----------------------------------------------------------------------------
`default_nettype none

module psar_rsp_stage
   import psar_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         load,
   input  wire rsp_item_type result,
   output logic              can_load,
   psar_rsp_if.source        rsp_chan
);

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type result_ff;

   assign can_load = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_chan.valid              = valid_ff;
   assign rsp_chan.cur_address        = result_ff.cur_address;
   assign rsp_chan.fine_x             = result_ff.fine_x;
   assign rsp_chan.toggle             = result_ff.toggle;
   assign rsp_chan.nmi_pulse          = result_ff.nmi_pulse;
   assign rsp_chan.vblank_status      = result_ff.vblank_status;
   assign rsp_chan.name_fetch_address = result_ff.name_fetch_address;
   assign rsp_chan.attr_fetch_address = result_ff.attr_fetch_address;

endmodule

`default_nettype wire
